### sv/pdot_pkg.sv
// Shared types and constants for the paged disk offset translator.
`timescale 1ns / 1ps

package pdot_pkg;

    localparam int CURSOR_W    = 28;
    localparam int PAGE_W      = 21;
    localparam int PHYS_W      = 32;
    localparam int TOTAL_W     = 8;
    localparam int MAP_IDX_W   = 7;
    localparam int SEEK_W      = 29;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 21;

    localparam int          MAP_DEPTH_DEF    = 128;
    localparam longint      DISK_BYTES_DEF   = 64'd134217728;
    localparam int          MAX_SEGMENTS_DEF = 64;

    localparam logic [PHYS_W-1:0]     UNALLOCATED    = 32'hFFFF_FFFF;
    localparam logic [PAGE_W-1:0]     PAGE_SIZE_RST  = 21'h10_0000;
    localparam logic [CURSOR_W-1:0]   CURSOR_MAX     = 28'hFFF_FFFF;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_SEEK  = 2'd1,
        KIND_READ  = 2'd2,
        KIND_WRITE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ANCHOR_START  = 2'd0,
        ANCHOR_CURSOR = 2'd1,
        ANCHOR_END    = 2'd2,
        ANCHOR_BAD    = 2'd3
    } t_anchor;

    typedef enum logic [2:0] {
        ST_SEGMENT  = 3'd0,
        ST_UNMAPPED = 3'd1,
        ST_SEEK_OK  = 3'd2,
        ST_SEEK_REJ = 3'd3,
        ST_LOADED   = 3'd4,
        ST_DONE     = 3'd5,
        ST_TRUNC    = 3'd6
    } t_status;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PAGES = 2'd1;

endpackage

### sv/paged_disk_offset_translator.sv
// Paged disk offset translator: page map, cursor, seek and request splitting.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+-----------------------------------
//  config  | in        | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//  item    | in        | i_valid / o_ready           | kind, map index/value, seek, count
//  result  | out       | o_valid / i_ready           | status, offsets, lengths, cursor
//
// Load and seek items go straight to the result state and wait there for i_ready.
// A read or write emits one result per segment and a final status, each held until
// i_ready; each segment is set by the 28-step shift-subtract divider (cursor by page
// size), then the map read, the 32x21 multiply, the offset add and the result state.
// One item is in flight at a time; o_ready is high only while idle.
// Synchronous active-low reset resets cursor and config; the page map is not cleared.
`timescale 1ns / 1ps

module paged_disk_offset_translator #(
    parameter int              MAP_DEPTH    = pdot_pkg::MAP_DEPTH_DEF,
    parameter longint unsigned DISK_BYTES   = pdot_pkg::DISK_BYTES_DEF,
    parameter int              MAX_SEGMENTS = pdot_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pdot_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pdot_pkg::CFG_DATA_W-1:0]      i_cfg_data,

    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [1:0]                           i_kind,
    input  logic [pdot_pkg::MAP_IDX_W-1:0]       i_map_index,
    input  logic [pdot_pkg::PHYS_W-1:0]          i_map_value,
    input  logic signed [pdot_pkg::SEEK_W-1:0]   i_seek_offset,
    input  logic [1:0]                           i_seek_anchor,
    input  logic [pdot_pkg::CURSOR_W-1:0]        i_byte_count,

    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [2:0]                           o_status,
    output logic [pdot_pkg::PHYS_W-1:0]          o_physical_offset,
    output logic [pdot_pkg::PAGE_W-1:0]          o_segment_length,
    output logic [pdot_pkg::CURSOR_W-1:0]        o_zero_fill_bytes,
    output logic [pdot_pkg::CURSOR_W-1:0]        o_position,
    output logic [pdot_pkg::CURSOR_W-1:0]        o_bytes_done,
    output logic                                 o_last
);

    localparam int MAP_AW  = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int SEG_W   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW      = pdot_pkg::CURSOR_W;
    localparam int PW      = pdot_pkg::PAGE_W;
    localparam int XW      = 36;   // seek arithmetic, covers disk sizes up to 2^32
    localparam logic [4:0]        DIV_LAST = 5'(CW - 1);
    localparam logic [SEG_W-1:0]  SEG_LIM  = SEG_W'(MAX_SEGMENTS - 1);
    localparam logic signed [XW-1:0] DISK_X = XW'(DISK_BYTES);
    localparam logic signed [XW-1:0] CMAX_X = XW'(pdot_pkg::CURSOR_MAX);
    localparam logic [31:0]       DEPTH_32 = 32'(MAP_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_LOOK,
        S_MUL,
        S_ADD,
        S_EMIT
    } t_state;

    t_state r_state;

    // configuration and architectural state
    logic [PW-1:0]                     r_page_size;
    logic [pdot_pkg::TOTAL_W-1:0]      r_total_pages;
    logic [CW-1:0]                     r_cursor;

    // request working registers
    logic                              r_is_read;
    logic [CW-1:0]                     r_count;
    logic [CW-1:0]                     r_done;
    logic [SEG_W-1:0]                  r_nseg;
    logic [4:0]                        r_step;
    logic [CW-1:0]                     r_quot;
    logic [PW-1:0]                     r_rem;
    logic [pdot_pkg::PHYS_W-1:0]       r_prod;
    logic [PW-1:0]                     r_len;

    // result register
    logic [2:0]                        r_status;
    logic [pdot_pkg::PHYS_W-1:0]       r_phys;
    logic [PW-1:0]                     r_seglen;
    logic [CW-1:0]                     r_fill;
    logic                              r_last;

    // page map
    logic [pdot_pkg::PHYS_W-1:0]       r_map [MAP_DEPTH];
    logic [pdot_pkg::PHYS_W-1:0]       r_rd_data;

    logic                              in_acc;
    logic [PW-1:0]                     ps_eff;
    logic [PW:0]                       div_trial;
    logic                              div_ge;
    logic [31:0]                       map_limit;
    logic                              page_ok;
    logic [PW-1:0]                     room;
    logic [31:0]                       load_idx;
    logic                              load_ok;
    logic signed [XW-1:0]              seek_base;
    logic signed [XW-1:0]              seek_target;
    logic                              seek_bad;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE);
    assign in_acc      = i_valid && o_ready;

    assign ps_eff    = (r_page_size == '0) ? PW'(1) : r_page_size;
    assign div_trial = {r_rem, r_quot[CW-1]};
    assign div_ge    = (div_trial >= {1'b0, ps_eff});

    assign map_limit = (32'(r_total_pages) < DEPTH_32) ? 32'(r_total_pages) : DEPTH_32;
    assign page_ok   = (32'(r_quot) < map_limit);
    assign room      = ps_eff - r_rem;

    assign load_idx = 32'(i_map_index);
    assign load_ok  = (load_idx < DEPTH_32);

    always_comb begin
        case (i_seek_anchor)
            pdot_pkg::ANCHOR_CURSOR: seek_base = XW'(r_cursor);
            pdot_pkg::ANCHOR_END:    seek_base = DISK_X;
            default:                 seek_base = '0;
        endcase
    end

    assign seek_target = seek_base + XW'(i_seek_offset);
    assign seek_bad    = (i_seek_anchor == pdot_pkg::ANCHOR_BAD) || seek_target[XW-1]
                       || (seek_target > DISK_X) || (seek_target > CMAX_X);

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_kind == pdot_pkg::KIND_LOAD) && load_ok) begin
            r_map[load_idx[MAP_AW-1:0]] <= i_map_value;
        end
        r_rd_data <= r_map[r_quot[MAP_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_size   <= pdot_pkg::PAGE_SIZE_RST;
            r_total_pages <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == pdot_pkg::CFG_PAGE_SIZE) begin
                r_page_size <= i_cfg_data[PW-1:0];
            end else if (i_cfg_index == pdot_pkg::CFG_TOTAL_PAGES) begin
                r_total_pages <= i_cfg_data[pdot_pkg::TOTAL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cursor <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_phys   <= '0;
                        r_seglen <= '0;
                        r_fill   <= '0;
                        r_done   <= '0;
                        r_last   <= 1'b1;
                        r_count  <= i_byte_count;
                        r_nseg   <= '0;
                        r_is_read <= (i_kind == pdot_pkg::KIND_READ);
                        case (i_kind)
                            pdot_pkg::KIND_LOAD: begin
                                r_status <= pdot_pkg::ST_LOADED;
                                r_state  <= S_EMIT;
                            end
                            pdot_pkg::KIND_SEEK: begin
                                if (seek_bad) begin
                                    r_status <= pdot_pkg::ST_SEEK_REJ;
                                end else begin
                                    r_status <= pdot_pkg::ST_SEEK_OK;
                                    r_cursor <= seek_target[CW-1:0];
                                end
                                r_state <= S_EMIT;
                            end
                            default: begin
                                r_state <= S_CHECK;
                            end
                        endcase
                    end
                end
                S_CHECK: begin
                    r_phys   <= '0;
                    r_seglen <= '0;
                    r_last   <= 1'b1;
                    if (r_count == '0) begin
                        r_status <= pdot_pkg::ST_DONE;
                        r_fill   <= '0;
                        r_state  <= S_EMIT;
                    end else if (r_nseg == SEG_LIM) begin
                        r_status <= pdot_pkg::ST_TRUNC;
                        r_fill   <= r_count;
                        r_state  <= S_EMIT;
                    end else begin
                        r_rem   <= '0;
                        r_quot  <= r_cursor;
                        r_step  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // one quotient bit per cycle
                    r_rem  <= div_ge ? PW'(div_trial - {1'b0, ps_eff}) : div_trial[PW-1:0];
                    r_quot <= {r_quot[CW-2:0], div_ge};
                    r_step <= r_step + 5'd1;
                    if (r_step == DIV_LAST) begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (!page_ok) begin
                        r_status <= pdot_pkg::ST_UNMAPPED;
                        r_fill   <= r_is_read ? r_count : '0;
                        r_state  <= S_EMIT;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_rd_data == pdot_pkg::UNALLOCATED) begin
                        r_status <= pdot_pkg::ST_UNMAPPED;
                        r_fill   <= r_is_read ? r_count : '0;
                        r_state  <= S_EMIT;
                    end else begin
                        r_prod  <= 32'(r_rd_data * {11'b0, ps_eff});
                        r_len   <= (r_count < CW'(room)) ? r_count[PW-1:0] : room;
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_status <= pdot_pkg::ST_SEGMENT;
                    r_phys   <= r_prod + 32'(r_rem);
                    r_seglen <= r_len;
                    r_fill   <= '0;
                    r_last   <= 1'b0;
                    r_cursor <= r_cursor + CW'(r_len);
                    r_count  <= r_count - CW'(r_len);
                    r_done   <= r_done + CW'(r_len);
                    r_nseg   <= r_nseg + SEG_W'(1);
                    r_state  <= S_EMIT;
                end
                S_EMIT: begin
                    if (i_ready) begin
                        r_state <= r_last ? S_IDLE : S_CHECK;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid           = (r_state == S_EMIT);
    assign o_status          = r_status;
    assign o_physical_offset = r_phys;
    assign o_segment_length  = r_seglen;
    assign o_zero_fill_bytes = r_fill;
    assign o_position        = r_cursor;
    assign o_bytes_done      = r_done;
    assign o_last            = r_last;

endmodule

### sv/pdot_checker.sv
// Port-level assertions for the paged disk offset translator, bound to the top level.
`timescale 1ns / 1ps

module pdot_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_valid,
    input logic                                 o_ready,
    input logic                                 o_valid,
    input logic [2:0]                           o_status,
    input logic [pdot_pkg::PHYS_W-1:0]          o_physical_offset,
    input logic [pdot_pkg::PAGE_W-1:0]          o_segment_length,
    input logic                                 o_last
);

    // reset leaves no result valid
    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // one item at a time: never ready while a result is shown
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid)
        else $error("input ready while result pending");

    // an accepted item blocks further input next cycle
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready right after accept");

    // segments are never final and carry bytes; other results carry none
    a_seg_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == pdot_pkg::ST_SEGMENT)) |->
            (!o_last && (o_segment_length != '0)))
        else $error("malformed segment result");

    a_nonseg_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != pdot_pkg::ST_SEGMENT)) |->
            (o_last && (o_segment_length == '0) && (o_physical_offset == '0)))
        else $error("malformed status result");

endmodule

bind paged_disk_offset_translator pdot_checker u_pdot_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_ready           (o_ready),
    .o_valid           (o_valid),
    .o_status          (o_status),
    .o_physical_offset (o_physical_offset),
    .o_segment_length  (o_segment_length),
    .o_last            (o_last)
);
